// ===== rtl/mcfm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfm_pkg: shared types and constants
// State encoding, controller/datapath command and status bundles, register
// indexes, fault thresholds and the target current table.
// ----------------------------------------------------------------------------
package mcfm_pkg;

  localparam int SAMPLE_BITS  = 12;
  localparam int NUM_SAMPLES  = 6;
  localparam int SAMPLE_IDX_W = $clog2(NUM_SAMPLES + 1);
  localparam int WIN_LEN      = 16;
  localparam int WIN_IDX_W    = $clog2(WIN_LEN);
  localparam int RANK_W       = $clog2(WIN_LEN + 1);
  localparam int SUM_W        = SAMPLE_BITS + $clog2(NUM_SAMPLES);
  localparam int TICK_W       = 8;
  localparam int CFG_DATA_W   = 12;
  localparam int CFG_INDEX_W  = 3;
  localparam int UNDER_W      = 4;
  localparam int WCOUNT_W     = 4;
  localparam int OVER_W       = 3;
  localparam int ENTRY_W      = 3;

  localparam logic [RANK_W-1:0]       MEDIAN_RANK = RANK_W'(WIN_LEN / 2);
  localparam logic [SAMPLE_IDX_W-1:0] LAST_SAMPLE = SAMPLE_IDX_W'(NUM_SAMPLES - 1);
  localparam logic [SAMPLE_IDX_W-1:0] FULL_COUNT  = SAMPLE_IDX_W'(NUM_SAMPLES);
  localparam logic [WIN_IDX_W-1:0]    LAST_AVG    = WIN_IDX_W'(WIN_LEN - 1);
  localparam logic [TICK_W-1:0]       TICK_MAX    = '1;
  localparam logic [UNDER_W-1:0]      UNDER_MAX   = '1;
  localparam logic [UNDER_W-1:0]      UNDER_LIMIT = UNDER_W'(3);
  localparam logic [WCOUNT_W-1:0]     WINDOW_LIMIT = WCOUNT_W'(7);
  localparam logic [OVER_W-1:0]       OVER_LIMIT  = OVER_W'(6);

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_OVERCURRENT_LIMIT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DROP_MARGIN       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ARM_TICKS         = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHECK_TICKS       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_TICKS        = 3'd4;

  localparam logic [SAMPLE_BITS-1:0] OVERCURRENT_RESET = 12'd476;
  localparam logic [SAMPLE_BITS-1:0] DROP_MARGIN_RESET = 12'd73;
  localparam logic [TICK_W-1:0]      ARM_TICKS_RESET   = 8'd10;
  localparam logic [TICK_W-1:0]      CHECK_TICKS_RESET = 8'd40;
  localparam logic [TICK_W-1:0]      HOLD_TICKS_RESET  = 8'd50;

  // command codes and switch codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;
  localparam logic [2:0] DIP_ALT_TABLE      = 3'd4;
  localparam logic [2:0] DIP_NO_OVERCURRENT = 3'd1;
  localparam logic [ENTRY_W-1:0] ENTRY_TOP_SPEED = 3'd4;
  localparam logic [ENTRY_W-1:0] ENTRY_CLEANING  = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_AVG_ADDR,
    ST_AVG_ACC,
    ST_AVG_WR,
    ST_CAND,
    ST_LATCH,
    ST_SCAN,
    ST_DRAIN,
    ST_EVAL,
    ST_CHECK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic do_tick;
    logic do_clear;
    logic do_store;
    logic avg_acc;
    logic avg_write;
    logic cand_read;
    logic cand_latch;
    logic scan;
    logic eval;
    logic check;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic accepted;
    logic is_tick;
    logic is_clear;
    logic samples_full;
    logic avg_last;
    logic window_end;
    logic scan_last;
    logic median_hit;
    logic out_free;
  } status_t;

  function automatic logic [SAMPLE_BITS-1:0] target_current(input logic alt,
                                                           input logic [ENTRY_W-1:0] entry);
    logic [SAMPLE_BITS-1:0] t;
    case (entry)
      3'd0:    t = alt ? 12'd100 : 12'd86;
      3'd1:    t = alt ? 12'd115 : 12'd100;
      3'd2:    t = alt ? 12'd130 : 12'd115;
      3'd3:    t = alt ? 12'd159 : 12'd144;
      3'd4:    t = alt ? 12'd173 : 12'd159;
      default: t = alt ? 12'd130 : 12'd115;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/mcfm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfm_if: item and result channels
// Valid/ready channels; one transfer per edge with valid and ready high.
// ----------------------------------------------------------------------------
interface mcfm_item_if;
  import mcfm_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   command;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   hold;
  logic                   running;
  logic                   cleaning;
  logic [2:0]             speed;
  logic [2:0]             dip_mode;

  modport source (output valid, command, sample, hold, running, cleaning, speed, dip_mode,
                  input ready);
  modport sink (input valid, command, sample, hold, running, cleaning, speed, dip_mode,
                output ready);
endinterface

interface mcfm_result_if;
  import mcfm_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   fault;
  logic [SAMPLE_BITS-1:0] median_current;
  logic                   window_done;

  modport source (output valid, fault, median_current, window_done, input ready);
  modport sink (input valid, fault, median_current, window_done, output ready);
endinterface

// ===== rtl/mcfm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfm_ram: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mcfm_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/mcfm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfm_ctrl: sequencing controller
// Steps one item through decode and, as needed, trimmed averaging, rank-based median
// search and the window checks, then hands the result to the output stage.
// ----------------------------------------------------------------------------
module mcfm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  mcfm_pkg::status_t status,
  output mcfm_pkg::cmd_t    cmd
);
  import mcfm_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (status.accepted) state_next = ST_DECODE;
      ST_DECODE: begin
        if (status.is_tick || status.is_clear || !status.samples_full) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_AVG_ADDR;
        end
      end
      ST_AVG_ADDR: state_next = ST_AVG_ACC;
      ST_AVG_ACC:  state_next = status.avg_last ? ST_AVG_WR : ST_AVG_ADDR;
      ST_AVG_WR:   state_next = status.window_end ? ST_CAND : ST_FINISH;
      ST_CAND:     state_next = ST_LATCH;
      ST_LATCH:    state_next = ST_SCAN;
      ST_SCAN:     if (status.scan_last) state_next = ST_DRAIN;
      ST_DRAIN:    state_next = ST_EVAL;
      ST_EVAL:     state_next = status.median_hit ? ST_CHECK : ST_CAND;
      ST_CHECK:    state_next = ST_FINISH;
      ST_FINISH:   if (status.out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE:   cmd.in_ready = 1'b1;
      ST_DECODE: begin
        cmd.do_tick  = status.is_tick;
        cmd.do_clear = !status.is_tick && status.is_clear;
        cmd.do_store = !status.is_tick && !status.is_clear && !status.samples_full;
      end
      ST_AVG_ACC: cmd.avg_acc    = 1'b1;
      ST_AVG_WR:  cmd.avg_write  = 1'b1;
      ST_CAND:    cmd.cand_read  = 1'b1;
      ST_LATCH:   cmd.cand_latch = 1'b1;
      ST_SCAN:    cmd.scan       = 1'b1;
      ST_EVAL:    cmd.eval       = 1'b1;
      ST_CHECK:   cmd.check      = 1'b1;
      ST_FINISH:  cmd.load_out   = status.out_free;
      default:    cmd = '0;
    endcase
  end

endmodule

// ===== rtl/mcfm_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfm_datapath: sample/average stores, median search and fault logic
// Holds the configuration, the monitor counters, both stores and the
// output register. Acts on commands from the controller.
// ----------------------------------------------------------------------------
module mcfm_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wen,
  input  logic [mcfm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mcfm_pkg::CFG_DATA_W-1:0]    cfg_data,
  mcfm_item_if.sink                          item,
  mcfm_result_if.source                      result,
  input  mcfm_pkg::cmd_t                     cmd,
  output mcfm_pkg::status_t                  status
);
  import mcfm_pkg::*;

  // configuration
  logic [SAMPLE_BITS-1:0] overcurrent_limit, drop_margin;
  logic [TICK_W-1:0]      arm_ticks, check_ticks, hold_ticks;

  // latched item
  logic                   command_q, hold_q, running_q, cleaning_q;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic [2:0]             speed_q, dip_q;

  // monitor state
  logic [SAMPLE_IDX_W-1:0] sample_index;
  logic [WIN_IDX_W-1:0]    average_index;
  logic [SAMPLE_BITS-1:0]  median_value, peak_value;
  logic [UNDER_W-1:0]      under_count;
  logic [WCOUNT_W-1:0]     window_count;
  logic [OVER_W-1:0]       over_count;
  logic [TICK_W-1:0]       cancel_timer;
  logic                    fault_flag, done;

  // averaging and median search
  logic [SAMPLE_IDX_W-1:0] avg_k;
  logic [SUM_W-1:0]        sum;
  logic [SAMPLE_BITS-1:0]  lo, hi, cand;
  logic [WIN_IDX_W-1:0]    cand_i, scan_j;
  logic [RANK_W-1:0]       lt_count, le_count;
  logic                    cmp_valid;
  logic [SAMPLE_BITS-1:0]  sample_rdata, avg_rdata, trimmed;
  logic [SUM_W-1:0]        trimmed_sum;

  // output stage
  logic                   out_valid, out_fault, out_done;
  logic [SAMPLE_BITS-1:0] out_median;

  logic accept;
  assign accept = item.valid && item.ready;
  assign item.ready = cmd.in_ready;

  mcfm_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(NUM_SAMPLES)) u_sample_ram (
    .clk   (clk),
    .we    (cmd.do_store),
    .waddr (sample_index),
    .wdata (sample_q),
    .raddr (avg_k),
    .rdata (sample_rdata)
  );

  assign trimmed_sum = sum - SUM_W'(lo) - SUM_W'(hi);
  assign trimmed     = trimmed_sum[SAMPLE_BITS+1:2];

  mcfm_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WIN_LEN)) u_average_ram (
    .clk   (clk),
    .we    (cmd.avg_write),
    .waddr (average_index),
    .wdata (trimmed),
    .raddr (cmd.cand_read ? cand_i : scan_j),
    .rdata (avg_rdata)
  );

  // status
  always_comb begin
    status.accepted     = accept;
    status.is_tick      = (command_q == CMD_TICK);
    status.is_clear     = hold_q || fault_flag;
    status.samples_full = (sample_index == FULL_COUNT);
    status.avg_last     = (avg_k == LAST_SAMPLE);
    status.window_end   = (average_index == LAST_AVG);
    status.scan_last    = (scan_j == LAST_AVG);
    status.median_hit   = (lt_count <= MEDIAN_RANK) && (le_count > MEDIAN_RANK);
    status.out_free     = !out_valid || result.ready;
  end

  // window checks
  logic [ENTRY_W-1:0]     entry;
  logic [SAMPLE_BITS-1:0] target;
  logic [SAMPLE_BITS-1:0] peak_n;
  logic [UNDER_W-1:0]     under_n;
  logic [WCOUNT_W-1:0]    wcount_n;
  logic [OVER_W-1:0]      over_n;
  logic [TICK_W-1:0]      timer_n;
  logic                   fault_n;

  always_comb begin
    if (cleaning_q) begin
      entry = ENTRY_CLEANING;
    end else if (speed_q > ENTRY_TOP_SPEED) begin
      entry = ENTRY_TOP_SPEED;
    end else begin
      entry = speed_q;
    end
    target   = target_current(dip_q == DIP_ALT_TABLE, entry);
    peak_n   = peak_value;
    under_n  = under_count;
    timer_n  = cancel_timer;
    fault_n  = fault_flag;
    wcount_n = window_count;
    over_n   = over_count;
    if (running_q) begin
      if (cancel_timer > arm_ticks) begin
        if (median_value > peak_n) peak_n = median_value;
        if (median_value > drop_margin && peak_n >= drop_margin &&
            median_value < peak_n - drop_margin) begin
          fault_n = 1'b1;
        end
      end
      if (cancel_timer > check_ticks) begin
        timer_n = hold_ticks;
        if (median_value < target && under_count != UNDER_MAX) begin
          under_n = under_count + 1'b1;
        end
      end else begin
        under_n = '0;
        peak_n  = '0;
      end
    end else begin
      under_n = '0;
      timer_n = '0;
      peak_n  = '0;
    end
    if (window_count > WINDOW_LIMIT) begin
      if (under_n > UNDER_LIMIT) fault_n = 1'b1;
      wcount_n = '0;
      under_n  = '0;
    end else begin
      wcount_n = window_count + 1'b1;
    end
    if (dip_q != DIP_NO_OVERCURRENT) begin
      over_n = (median_value > overcurrent_limit) ? over_count + 1'b1 : '0;
      if (over_n > OVER_LIMIT) begin
        over_n  = '0;
        fault_n = 1'b1;
      end
    end
  end

  // control and monitor state
  always_ff @(posedge clk) begin
    if (rst) begin
      overcurrent_limit <= OVERCURRENT_RESET;
      drop_margin       <= DROP_MARGIN_RESET;
      arm_ticks         <= ARM_TICKS_RESET;
      check_ticks       <= CHECK_TICKS_RESET;
      hold_ticks        <= HOLD_TICKS_RESET;
      sample_index      <= '0;
      average_index     <= '0;
      median_value      <= '0;
      peak_value        <= '0;
      under_count       <= '0;
      window_count      <= '0;
      over_count        <= '0;
      cancel_timer      <= '0;
      fault_flag        <= 1'b0;
      done              <= 1'b0;
      avg_k             <= '0;
      cand_i            <= '0;
      scan_j            <= '0;
      cmp_valid         <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          CFG_OVERCURRENT_LIMIT: overcurrent_limit <= cfg_data;
          CFG_DROP_MARGIN:       drop_margin       <= cfg_data;
          CFG_ARM_TICKS:         arm_ticks         <= cfg_data[TICK_W-1:0];
          CFG_CHECK_TICKS:       check_ticks       <= cfg_data[TICK_W-1:0];
          CFG_HOLD_TICKS:        hold_ticks        <= cfg_data[TICK_W-1:0];
          default: ;
        endcase
      end

      if (cmd.do_tick && cancel_timer != TICK_MAX) begin
        cancel_timer <= cancel_timer + 1'b1;
      end
      if (cmd.do_clear) begin
        sample_index <= '0;
        under_count  <= '0;
        over_count   <= '0;
        window_count <= '0;
        peak_value   <= '0;
        cancel_timer <= '0;
      end
      if (cmd.do_store) begin
        sample_index <= sample_index + 1'b1;
      end

      if (cmd.avg_acc) begin
        avg_k <= status.avg_last ? '0 : avg_k + 1'b1;
      end
      if (cmd.avg_write) begin
        sample_index  <= '0;
        average_index <= average_index + 1'b1;
      end

      cmp_valid <= cmd.scan;
      if (cmd.cand_latch) begin
        scan_j <= '0;
      end
      if (cmd.scan) begin
        scan_j <= scan_j + 1'b1;
      end
      if (cmd.eval) begin
        if (status.median_hit) begin
          median_value <= cand;
          cand_i       <= '0;
        end else begin
          cand_i <= cand_i + 1'b1;
        end
      end

      if (cmd.check) begin
        peak_value   <= peak_n;
        under_count  <= under_n;
        window_count <= wcount_n;
        over_count   <= over_n;
        cancel_timer <= timer_n;
        fault_flag   <= fault_n;
        done         <= 1'b1;
      end

      if (cmd.load_out) begin
        out_valid <= 1'b1;
        done      <= 1'b0;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      command_q  <= item.command;
      sample_q   <= item.sample;
      hold_q     <= item.hold;
      running_q  <= item.running;
      cleaning_q <= item.cleaning;
      speed_q    <= item.speed;
      dip_q      <= item.dip_mode;
    end
    if (cmd.avg_acc) begin
      if (avg_k == '0) begin
        sum <= SUM_W'(sample_rdata);
        lo  <= sample_rdata;
        hi  <= sample_rdata;
      end else begin
        sum <= sum + SUM_W'(sample_rdata);
        if (sample_rdata < lo) lo <= sample_rdata;
        if (sample_rdata > hi) hi <= sample_rdata;
      end
    end
    if (cmd.cand_latch) begin
      cand     <= avg_rdata;
      lt_count <= '0;
      le_count <= '0;
    end else if (cmp_valid) begin
      if (avg_rdata < cand)  lt_count <= lt_count + 1'b1;
      if (avg_rdata <= cand) le_count <= le_count + 1'b1;
    end
    if (cmd.load_out) begin
      out_fault  <= fault_flag;
      out_median <= median_value;
      out_done   <= done;
    end
  end

  assign result.valid          = out_valid;
  assign result.fault          = out_fault;
  assign result.median_current = out_median;
  assign result.window_done    = out_done;

endmodule

// ===== rtl/motor_current_fault_monitor.sv =====
`timescale 1ns / 1ps
// Sequencing: a tick, a hold or a stored sample goes from decode straight to the output stage;
//   an averaging call also accumulates the six stored samples; a call that closes a window
//   adds the median search (up to 16 candidates, each ranked against all 16 averages, one RAM read port).
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset: synchronous rst clears the counters, timer, median, fault and output stage and
//   loads the register defaults; the sample and average stores are not cleared.
// ----------------------------------------------------------------------------
// motor_current_fault_monitor: trimmed-mean / median current fault monitor
// Controller and datapath joined by command and status bundles.
// ----------------------------------------------------------------------------
module motor_current_fault_monitor (
  input  logic                             clk,
  input  logic                             rst,
  mcfm_item_if.sink                        item,
  mcfm_result_if.source                    result,
  input  logic                             cfg_wen,
  input  logic [mcfm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mcfm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mcfm_pkg::*;

  cmd_t    cmd;
  status_t status;

  mcfm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  mcfm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .result    (result),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
